// ===== rtl/eub_pkg.sv =====
`timescale 1ns / 1ps
package eub_pkg;

	// Symbology register codes
	localparam logic [1:0] SYM_EAN13 = 2'd0;
	localparam logic [1:0] SYM_UPCA  = 2'd1;
	localparam logic [1:0] SYM_EAN8  = 2'd2;

	// Configuration register indexes
	localparam logic CFG_SYMBOLOGY = 1'b0;
	localparam logic CFG_GEN_CHECK = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Bit positions of the group mask, in emission order
	localparam int GRP_START  = 0;
	localparam int GRP_DIGIT  = 1;
	localparam int GRP_CENTER = 2;
	localparam int GRP_CHECK  = 3;
	localparam int GRP_END    = 4;
	localparam int GRP_NUM    = 5;

	typedef enum logic [2:0] {
		KIND_START  = 3'd0,
		KIND_LEFT   = 3'd1,
		KIND_CENTER = 3'd2,
		KIND_RIGHT  = 3'd3,
		KIND_CHECK  = 3'd4,
		KIND_END    = 3'd5
	} group_kind_t;

	// One classified digit: which groups it causes and how to draw its digit group
	typedef struct packed {
		logic [GRP_NUM-1:0] mask;
		group_kind_t        digit_kind;
		logic [3:0]         digit;
		logic               reversed;
		logic               bar;
		logic [3:0]         chk;
	} queue_entry_t;

	// Module widths of a set A digit, first element in the top three bits
	function automatic logic [11:0] set_a_widths(input logic [3:0] d);
		logic [11:0] w;
		case (d)
			4'd0:    w = {3'd3, 3'd2, 3'd1, 3'd1};
			4'd1:    w = {3'd2, 3'd2, 3'd2, 3'd1};
			4'd2:    w = {3'd2, 3'd1, 3'd2, 3'd2};
			4'd3:    w = {3'd1, 3'd4, 3'd1, 3'd1};
			4'd4:    w = {3'd1, 3'd1, 3'd3, 3'd2};
			4'd5:    w = {3'd1, 3'd2, 3'd3, 3'd1};
			4'd6:    w = {3'd1, 3'd1, 3'd1, 3'd4};
			4'd7:    w = {3'd1, 3'd3, 3'd1, 3'd2};
			4'd8:    w = {3'd1, 3'd2, 3'd1, 3'd3};
			4'd9:    w = {3'd3, 3'd1, 3'd1, 3'd2};
			default: w = '0;
		endcase
		return w;
	endfunction

	// Bit k set: left digit k of an EAN-13 symbol uses set B
	function automatic logic [7:0] parity_b(input logic [3:0] lead);
		logic [7:0] p;
		case (lead)
			4'd0:    p = 8'h00;
			4'd1:    p = 8'h34;
			4'd2:    p = 8'h2C;
			4'd3:    p = 8'h1C;
			4'd4:    p = 8'h32;
			4'd5:    p = 8'h26;
			4'd6:    p = 8'h0E;
			4'd7:    p = 8'h2A;
			4'd8:    p = 8'h1A;
			4'd9:    p = 8'h16;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/eub_front.sv =====
`timescale 1ns / 1ps
module eub_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic                  cfg_index,
	input  logic [1:0]            cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [3:0]            digit,
	output logic                  enq_valid,
	input  logic                  enq_ready,
	output eub_pkg::queue_entry_t enq_entry
);
	import eub_pkg::*;

	logic [1:0] symbology_q;
	logic       gen_check_q;
	logic [3:0] pos_q;
	logic [3:0] lead_q;
	logic [3:0] sum_q;

	logic [3:0] total;
	logic [3:0] data_len;
	logic [3:0] left_end;
	logic [3:0] p;
	logic       is_lead;
	logic       is_left;
	logic       is_last;
	logic       use_b;
	logic [2:0] par_idx;
	logic [7:0] par_bits;
	logic       wgt3;
	logic [5:0] prod;
	logic [5:0] acc;
	logic [3:0] new_sum;
	logic [3:0] chk;
	logic       accept;

	always_comb begin
		case (symbology_q)
			SYM_EAN13: begin
				total    = 4'd13;
				left_end = 4'd7;
			end
			SYM_UPCA: begin
				total    = 4'd12;
				left_end = 4'd6;
			end
			default: begin
				total    = 4'd8;
				left_end = 4'd4;
			end
		endcase
	end

	assign data_len = total - {3'd0, gen_check_q};
	assign p        = (pos_q >= data_len) ? 4'd0 : pos_q;
	assign is_lead  = (symbology_q == SYM_EAN13) && (p == 4'd0);
	assign is_left  = !is_lead && (p < left_end);
	assign is_last  = (p == data_len - 4'd1);

	assign par_idx  = p[2:0] - 3'd1;
	assign par_bits = parity_b(lead_q);
	assign use_b    = (symbology_q == SYM_EAN13) && par_bits[par_idx];

	// weight 3 on the rightmost data digit, alternating leftward
	assign wgt3 = data_len[0] ^ p[0];
	assign prod = wgt3 ? ({2'd0, digit} + {1'b0, digit, 1'b0}) : {2'd0, digit};
	assign acc  = {2'd0, sum_q} + prod;

	always_comb begin
		if (!gen_check_q)
			new_sum = sum_q;
		else if (acc >= 6'd30)
			new_sum = 4'(acc - 6'd30);
		else if (acc >= 6'd20)
			new_sum = 4'(acc - 6'd20);
		else if (acc >= 6'd10)
			new_sum = 4'(acc - 6'd10);
		else
			new_sum = acc[3:0];
	end

	assign chk = (new_sum == 4'd0) ? 4'd0 : 4'd10 - new_sum;

	assign in_stall  = !enq_ready;
	assign accept    = in_valid && !in_stall;
	// drop digits above nine and anything under the undefined symbology
	assign enq_valid = accept && (digit <= 4'd9) && (symbology_q != 2'd3);

	always_comb begin
		enq_entry                  = '0;
		enq_entry.mask[GRP_START]  = (p == 4'd0);
		enq_entry.mask[GRP_DIGIT]  = !is_lead;
		enq_entry.mask[GRP_CENTER] = is_left && (p == left_end - 4'd1);
		enq_entry.mask[GRP_CHECK]  = is_last && gen_check_q;
		enq_entry.mask[GRP_END]    = is_last;
		enq_entry.digit_kind       = is_left ? KIND_LEFT : KIND_RIGHT;
		enq_entry.digit            = digit;
		enq_entry.reversed         = is_left && use_b;
		enq_entry.bar              = !is_left;
		enq_entry.chk              = chk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbology_q <= SYM_EAN13;
			gen_check_q <= 1'b1;
			pos_q       <= '0;
			lead_q      <= '0;
			sum_q       <= '0;
		end else if (cfg_write_en) begin
			// any write aborts the symbol in progress
			if (cfg_index == CFG_SYMBOLOGY)
				symbology_q <= cfg_data;
			else
				gen_check_q <= cfg_data[0];
			pos_q  <= '0;
			lead_q <= '0;
			sum_q  <= '0;
		end else if (enq_valid) begin
			if (is_last) begin
				pos_q  <= '0;
				lead_q <= '0;
				sum_q  <= '0;
			end else begin
				pos_q <= p + 4'd1;
				sum_q <= new_sum;
				if (is_lead)
					lead_q <= digit;
			end
		end
	end

endmodule

// ===== rtl/eub_queue.sv =====
`timescale 1ns / 1ps
module eub_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  eub_pkg::queue_entry_t wr_entry,
	output logic                  rd_valid,
	input  logic                  rd_pop,
	output eub_pkg::queue_entry_t rd_entry
);
	import eub_pkg::*;

	queue_entry_t        slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign wr_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = slots_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			slots_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + (QUEUE_AW+1)'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - (QUEUE_AW+1)'(1);
		end
	end

endmodule

// ===== rtl/eub_back.sv =====
`timescale 1ns / 1ps
module eub_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_valid,
	output logic                  rd_pop,
	input  eub_pkg::queue_entry_t rd_entry,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            group_kind,
	output logic [2:0]            element_count,
	output logic [2:0]            width_a,
	output logic [2:0]            width_b,
	output logic [2:0]            width_c,
	output logic [2:0]            width_d,
	output logic [2:0]            width_e,
	output logic                  starts_with_bar,
	output logic [3:0]            check_value,
	output logic                  last_of_run
);
	import eub_pkg::*;

	logic [GRP_NUM-1:0] done_q;
	logic [GRP_NUM-1:0] remaining;
	logic [GRP_NUM-1:0] sel;
	logic [GRP_NUM-1:0] rest;
	logic               load;
	logic [3:0]         shape_digit;
	logic [11:0]        w;

	logic               valid_q;
	group_kind_t        kind_q;
	logic [2:0]         count_q;
	logic [2:0]         wa_q, wb_q, wc_q, wd_q, we_q;
	logic               bar_q;
	logic [3:0]         chk_q;
	logic               last_q;

	group_kind_t        n_kind;
	logic [2:0]         n_count;
	logic [2:0]         n_wa, n_wb, n_wc, n_wd, n_we;
	logic               n_bar;
	logic [3:0]         n_chk;

	assign remaining = rd_entry.mask & ~done_q;
	assign sel       = remaining & (~remaining + GRP_NUM'(1));
	assign rest      = remaining & ~sel;
	assign load      = rd_valid && (!valid_q || !out_stall);
	assign rd_pop    = load && (rest == '0);

	assign shape_digit = sel[GRP_CHECK] ? rd_entry.chk : rd_entry.digit;
	assign w           = set_a_widths(shape_digit);

	always_comb begin
		n_kind  = KIND_START;
		n_count = 3'd3;
		n_wa    = 3'd1;
		n_wb    = 3'd1;
		n_wc    = 3'd1;
		n_wd    = 3'd0;
		n_we    = 3'd0;
		n_bar   = 1'b1;
		n_chk   = 4'd0;
		if (sel[GRP_DIGIT] || sel[GRP_CHECK]) begin
			n_count = 3'd4;
			if (sel[GRP_DIGIT] && rd_entry.reversed) begin
				n_wa = w[2:0];
				n_wb = w[5:3];
				n_wc = w[8:6];
				n_wd = w[11:9];
			end else begin
				n_wa = w[11:9];
				n_wb = w[8:6];
				n_wc = w[5:3];
				n_wd = w[2:0];
			end
			if (sel[GRP_DIGIT]) begin
				n_kind = rd_entry.digit_kind;
				n_bar  = rd_entry.bar;
			end else begin
				n_kind = KIND_CHECK;
				n_chk  = rd_entry.chk;
			end
		end else if (sel[GRP_CENTER]) begin
			n_kind  = KIND_CENTER;
			n_count = 3'd5;
			n_wd    = 3'd1;
			n_we    = 3'd1;
			n_bar   = 1'b0;
		end else if (sel[GRP_END]) begin
			n_kind = KIND_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				done_q  <= (rest == '0) ? '0 : (done_q | sel);
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= n_kind;
			count_q <= n_count;
			wa_q    <= n_wa;
			wb_q    <= n_wb;
			wc_q    <= n_wc;
			wd_q    <= n_wd;
			we_q    <= n_we;
			bar_q   <= n_bar;
			chk_q   <= n_chk;
			last_q  <= (rest == '0);
		end
	end

	assign out_valid       = valid_q;
	assign group_kind      = kind_q;
	assign element_count   = count_q;
	assign width_a         = wa_q;
	assign width_b         = wb_q;
	assign width_c         = wc_q;
	assign width_d         = wd_q;
	assign width_e         = we_q;
	assign starts_with_bar = bar_q;
	assign check_value     = chk_q;
	assign last_of_run     = last_q;

endmodule

// ===== rtl/ean_upc_bar_width_encoder_unit.sv =====
`timescale 1ns / 1ps
// EAN-13 / UPC-A / EAN-8 bar width encoder. Feed the digits of a symbol leftmost
// first, one request per digit; the block returns the symbol's element groups
// (start guard, left digits, center guard, right digits, optional generated
// check digit, end guard) with bar/space widths in modules. A digit request is
// taken whenever the four-entry queue between the classifier and the group
// emitter has room, so digits can arrive back to back. The emitter produces
// one group per cycle into the output register unless the output stalls, so a
// digit holds the output for each of its groups, up to three for the final
// digit with check generation. The first group of a digit is written into a
// queue slot and then into the output register, where it waits until accepted.
// Digits above nine and digits under symbology code three produce no group. Any
// configuration write restarts the symbol; write only while idle.
module ean_upc_bar_width_encoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] digit,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] group_kind,
	output logic [2:0] element_count,
	output logic [2:0] width_a,
	output logic [2:0] width_b,
	output logic [2:0] width_c,
	output logic [2:0] width_d,
	output logic [2:0] width_e,
	output logic       starts_with_bar,
	output logic [3:0] check_value,
	output logic       last_of_run
);
	import eub_pkg::*;

	logic         enq_valid;
	logic         enq_ready;
	queue_entry_t enq_entry;
	logic         rd_valid;
	logic         rd_pop;
	queue_entry_t rd_entry;

	// classify each digit, track position, leading digit and check sum
	eub_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.digit        (digit),
		.enq_valid    (enq_valid),
		.enq_ready    (enq_ready),
		.enq_entry    (enq_entry)
	);

	// decouple the classifier from the emitter
	eub_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (enq_valid),
		.wr_ready (enq_ready),
		.wr_entry (enq_entry),
		.rd_valid (rd_valid),
		.rd_pop   (rd_pop),
		.rd_entry (rd_entry)
	);

	// expand each queued digit into its groups, one per cycle unless the output stalls
	eub_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rd_valid        (rd_valid),
		.rd_pop          (rd_pop),
		.rd_entry        (rd_entry),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.group_kind      (group_kind),
		.element_count   (element_count),
		.width_a         (width_a),
		.width_b         (width_b),
		.width_c         (width_c),
		.width_d         (width_d),
		.width_e         (width_e),
		.starts_with_bar (starts_with_bar),
		.check_value     (check_value),
		.last_of_run     (last_of_run)
	);

endmodule
